/* src/gcdlcm_pkg.sv */
// shared constants and controller/datapath interface types for the gcd/lcm unit
package gcdlcm_pkg;

    localparam int DEF_OPERAND_WIDTH = 32;
    localparam int IN_WIDTH          = 32;
    localparam int GCD_WIDTH         = 32;
    localparam int LCM_WIDTH         = 64;

    typedef struct packed {
        logic load;
        logic gcd_step;
        logic div_init;
        logic div_step;
        logic mul;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic invalid;
        logic gcd_done;
        logic div_last;
    } t_dp_status;

endpackage

/* src/gcd_lcm_unit.sv */
// top level of the gcd/lcm unit: stream ports, controller and datapath
// usage:
//   an operand pair is a transfer on the s_axis side (operand_a in tdata[31:0],
//   operand_b in tdata[63:32]); only the low OPERAND_WIDTH bits of each are used
//   the result is a transfer on the m_axis side: gcd in tdata[31:0], lcm at
//   double width in tdata[95:32], invalid flag in tuser
//   a zero operand gives gcd 0, lcm 0 and invalid set
// sequence: a load, then one binary gcd step per cycle until the two
//   values meet and a check that sees it, a divider setup, the restoring
//   divider for a/gcd, a multiply and a load into the result register;
//   the run time is set by the gcd loop and the one-bit-per-cycle divider
//   an invalid pair skips the gcd loop, the division and the multiply and
//   goes straight to the result register
// throughput: one pair at a time; tready is high only while the unit is idle,
//   and the next pair may be taken while a finished result still waits
// reset: synchronous, active low; clears the state machine and the output valid
// stall: a held result stays in the output register, and a later result waits
//   in the last stage until the receiver takes it
module gcd_lcm_unit
    import gcdlcm_pkg::*;
#(
    parameter int OPERAND_WIDTH = DEF_OPERAND_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [2*IN_WIDTH-1:0]           i_s_axis_tdata,  // operand_a, operand_b
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [GCD_WIDTH+LCM_WIDTH-1:0]  o_m_axis_tdata,  // gcd_value, lcm_value
    output logic                            o_m_axis_tuser   // invalid
);

    t_dp_cmd              cmd;
    t_dp_status           status;
    logic [GCD_WIDTH-1:0] gcd_value;
    logic [LCM_WIDTH-1:0] lcm_value;
    logic                 invalid;

    gcdlcm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    gcdlcm_dp #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_operand_a (i_s_axis_tdata[IN_WIDTH-1:0]),
        .i_operand_b (i_s_axis_tdata[2*IN_WIDTH-1:IN_WIDTH]),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_gcd_value (gcd_value),
        .o_lcm_value (lcm_value),
        .o_invalid   (invalid)
    );

    assign o_m_axis_tdata = {lcm_value, gcd_value};
    assign o_m_axis_tuser = invalid;

endmodule

/* src/gcdlcm_dp.sv */
// datapath: binary gcd, serial restoring divider, multiplier and result register
module gcdlcm_dp
    import gcdlcm_pkg::*;
#(
    parameter int OPERAND_WIDTH = DEF_OPERAND_WIDTH
) (
    input  logic                  i_clk,
    input  logic [IN_WIDTH-1:0]   i_operand_a,
    input  logic [IN_WIDTH-1:0]   i_operand_b,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    output logic [GCD_WIDTH-1:0]  o_gcd_value,
    output logic [LCM_WIDTH-1:0]  o_lcm_value,
    output logic                  o_invalid
);

    localparam int W  = OPERAND_WIDTH;
    localparam int KW = $clog2(W);
    localparam int PW = 2 * W;

    logic [W-1:0]   r_a, r_b, r_a_orig, r_b_orig, r_g, r_quo, r_rem;
    logic [KW-1:0]  r_k, r_cnt;
    logic           r_inv;
    logic [PW-1:0]  r_prod;
    logic [GCD_WIDTH-1:0] r_out_gcd;
    logic [LCM_WIDTH-1:0] r_out_lcm;
    logic           r_out_inv;

    logic [W-1:0]   n_a, n_b;
    logic [KW-1:0]  n_k;
    logic [W:0]     a_minus_b;
    logic [W-1:0]   b_minus_a;
    logic [W:0]     div_shift;
    logic [W:0]     div_trial;
    logic           div_bit;

    // one step of the binary gcd
    always_comb begin
        a_minus_b = {1'b0, r_a} - {1'b0, r_b};
        b_minus_a = r_b - r_a;
        n_a = r_a;
        n_b = r_b;
        n_k = r_k;
        if (!r_a[0] && !r_b[0]) begin
            n_a = r_a >> 1;
            n_b = r_b >> 1;
            n_k = r_k + 1'b1;
        end else if (!r_a[0]) begin
            n_a = r_a >> 1;
        end else if (!r_b[0]) begin
            n_b = r_b >> 1;
        end else if (a_minus_b[W]) begin
            n_b = b_minus_a;
        end else begin
            n_a = a_minus_b[W-1:0];
        end
    end

    // one step of the restoring divider
    always_comb begin
        div_shift = {r_rem, r_quo[W-1]};
        div_trial = div_shift - {1'b0, r_g};
        div_bit   = !div_trial[W];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a      <= i_operand_a[W-1:0];
            r_b      <= i_operand_b[W-1:0];
            r_a_orig <= i_operand_a[W-1:0];
            r_b_orig <= i_operand_b[W-1:0];
            r_k      <= '0;
            r_inv    <= (i_operand_a[W-1:0] == '0) || (i_operand_b[W-1:0] == '0);
        end else if (i_cmd.gcd_step) begin
            r_a <= n_a;
            r_b <= n_b;
            r_k <= n_k;
        end
        if (i_cmd.div_init) begin
            r_g   <= r_a << r_k;
            r_rem <= '0;
            r_quo <= r_a_orig;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= div_bit ? div_trial[W-1:0] : div_shift[W-1:0];
            r_quo <= {r_quo[W-2:0], div_bit};
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.mul) begin
            r_prod <= PW'(r_quo) * PW'(r_b_orig);
        end
        if (i_cmd.out_load) begin
            r_out_inv <= r_inv;
            r_out_gcd <= r_inv ? '0 : GCD_WIDTH'(r_g);
            r_out_lcm <= r_inv ? '0 : LCM_WIDTH'(r_prod);
        end
    end

    assign o_status.invalid  = r_inv;
    assign o_status.gcd_done = (r_a == r_b);
    assign o_status.div_last = (r_cnt == KW'(W - 1));

    assign o_gcd_value = r_out_gcd;
    assign o_lcm_value = r_out_lcm;
    assign o_invalid   = r_out_inv;

endmodule

/* src/gcdlcm_ctrl.sv */
// controller state machine sequencing gcd, division, multiply and result transfer
module gcdlcm_ctrl
    import gcdlcm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    input  t_dp_status  i_status,
    output t_dp_cmd     o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GCD,
        S_DIVINIT,
        S_DIV,
        S_MUL,
        S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_GCD;
                end
            end
            S_GCD: begin
                if (i_status.invalid) begin
                    n_state = S_OUT;
                end else if (i_status.gcd_done) begin
                    n_state = S_DIVINIT;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            S_DIVINIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
